// File: hw/rtl/rpid_pkg.sv
// Shared types, register indexes, reset values and the control store for the rate PID.
// Used by rpid_dpath and rate_pid_with_integral_threshold; depends on nothing else.
package rpid_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SETPOINT    = 3'd0,
    REG_GAIN_PROP   = 3'd1,
    REG_GAIN_INTEG  = 3'd2,
    REG_GAIN_DERIV  = 3'd3,
    REG_STEP_PERIOD = 3'd4,
    REG_STEP_RATE   = 3'd5,
    REG_INTEG_THR   = 3'd6
  } reg_idx_t;

  localparam int CFG_DATA_W = 24;

  localparam logic [7:0]  RST_SETPOINT    = 8'd0;
  localparam logic [23:0] RST_GAIN_PROP   = 24'(-318505);
  localparam logic [23:0] RST_GAIN_INTEG  = 24'(-5354291);
  localparam logic [23:0] RST_GAIN_DERIV  = 24'd22145;
  localparam logic [15:0] RST_STEP_PERIOD = 16'd1311;
  localparam logic [13:0] RST_STEP_RATE   = 14'd50;
  localparam logic [15:0] RST_INTEG_THR   = 16'd0;

  // Configuration as seen by the datapath. Signed fields are reinterpreted where used.
  typedef struct packed {
    logic [7:0]  setpoint;
    logic [23:0] gain_prop;
    logic [23:0] gain_integ;
    logic [23:0] gain_deriv;
    logic [15:0] step_period;
    logic [13:0] step_rate;
    logic [15:0] integ_threshold;
  } cfg_t;

  // Operand pair routed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_E_PER,
    MUL_DIFF_RATE,
    MUL_GD_DERIV,
    MUL_GP_E,
    MUL_G_AH,
    MUL_G_AL
  } mul_sel_t;

  // Datapath register action of a step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIFF,
    OP_ACC_UPD,
    OP_TAKE_MAG,
    OP_SUM_LOAD,
    OP_SUM_ADD,
    OP_PH_SAVE,
    OP_ITERM,
    OP_SUM_ITERM,
    OP_MAG,
    OP_EMIT
  } op_t;

  // Condition under which the sequencer leaves a step.
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_IN,
    C_OUT
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_DIFF     = 4'd1;
  localparam step_t STEP_ACC      = 4'd2;
  localparam step_t STEP_MAGS     = 4'd3;
  localparam step_t STEP_DTERM    = 4'd4;
  localparam step_t STEP_PTERM    = 4'd5;
  localparam step_t STEP_PH       = 4'd6;
  localparam step_t STEP_ITERM    = 4'd7;
  localparam step_t STEP_SUM_I    = 4'd8;
  localparam step_t STEP_MAG      = 4'd9;
  localparam step_t STEP_EMIT     = 4'd10;

  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
    cond_t    cond;
    step_t    next;
  } uword_t;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    mul_sel_t mul;
    op_t      op;
    logic     go;
  } dp_ctl_t;

  function automatic uword_t ucode_rom(input step_t addr);
    uword_t w;
    w = '{mul: MUL_NONE, op: OP_NOP, cond: C_ALWAYS, next: STEP_IDLE};
    unique case (addr)
      STEP_IDLE:  w = '{mul: MUL_NONE,      op: OP_LOAD,      cond: C_IN,     next: STEP_DIFF};
      STEP_DIFF:  w = '{mul: MUL_E_PER,     op: OP_DIFF,      cond: C_ALWAYS, next: STEP_ACC};
      STEP_ACC:   w = '{mul: MUL_DIFF_RATE, op: OP_ACC_UPD,   cond: C_ALWAYS, next: STEP_MAGS};
      STEP_MAGS:  w = '{mul: MUL_GD_DERIV,  op: OP_TAKE_MAG,  cond: C_ALWAYS, next: STEP_DTERM};
      STEP_DTERM: w = '{mul: MUL_GP_E,      op: OP_SUM_LOAD,  cond: C_ALWAYS, next: STEP_PTERM};
      STEP_PTERM: w = '{mul: MUL_G_AH,      op: OP_SUM_ADD,   cond: C_ALWAYS, next: STEP_PH};
      STEP_PH:    w = '{mul: MUL_G_AL,      op: OP_PH_SAVE,   cond: C_ALWAYS, next: STEP_ITERM};
      STEP_ITERM: w = '{mul: MUL_NONE,      op: OP_ITERM,     cond: C_ALWAYS, next: STEP_SUM_I};
      STEP_SUM_I: w = '{mul: MUL_NONE,      op: OP_SUM_ITERM, cond: C_ALWAYS, next: STEP_MAG};
      STEP_MAG:   w = '{mul: MUL_NONE,      op: OP_MAG,       cond: C_ALWAYS, next: STEP_EMIT};
      STEP_EMIT:  w = '{mul: MUL_NONE,      op: OP_EMIT,      cond: C_OUT,    next: STEP_IDLE};
      default:    w = '{mul: MUL_NONE,      op: OP_NOP,       cond: C_ALWAYS, next: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/rate_pid_with_integral_threshold.sv
// Top level of the rate PID with thresholded integration: configuration registers,
// microcoded sequencer and output register; instantiates rpid_dpath, uses rpid_pkg.
//
//   Port group  Direction  Handshake          Payload
//   in_         input      in_valid/in_stall  in_rate_sample
//   out_        output     out_valid/out_stall out_drive, out_error_now
//   cfg_        input      cfg_we             cfg_addr, cfg_wdata
//
// A transaction runs through an eleven-step control program; most steps drive the one
// shared 33x33 multiplier or one wide adder, the output register is loaded in the last step
// once that register is free, and a new sample is taken only in the idle step.
// rst_n is synchronous and active low; it restores the register reset values and clears
// the integral and the previous error.
// The output register holds a result until taken; the last step waits there while
// out_stall keeps the previous result in place. in_stall is high outside the idle step.
module rate_pid_with_integral_threshold import rpid_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_rate_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_drive,
  output logic signed [16:0]    out_error_now,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t               cfg_r;
  step_t              step_r;
  step_t              step_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [15:0] out_drive_r;
  logic signed [16:0] out_error_now_r;

  uword_t             uw;
  dp_ctl_t            ctl;
  logic               cond_ok;
  logic               slot_free;
  logic               emit;
  logic signed [15:0] dp_drive;
  logic signed [16:0] dp_error_now;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint        <= RST_SETPOINT;
      cfg_r.gain_prop       <= RST_GAIN_PROP;
      cfg_r.gain_integ      <= RST_GAIN_INTEG;
      cfg_r.gain_deriv      <= RST_GAIN_DERIV;
      cfg_r.step_period     <= RST_STEP_PERIOD;
      cfg_r.step_rate       <= RST_STEP_RATE;
      cfg_r.integ_threshold <= RST_INTEG_THR;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SETPOINT:    cfg_r.setpoint        <= cfg_wdata[7:0];
        REG_GAIN_PROP:   cfg_r.gain_prop       <= cfg_wdata[23:0];
        REG_GAIN_INTEG:  cfg_r.gain_integ      <= cfg_wdata[23:0];
        REG_GAIN_DERIV:  cfg_r.gain_deriv      <= cfg_wdata[23:0];
        REG_STEP_PERIOD: cfg_r.step_period     <= cfg_wdata[15:0];
        REG_STEP_RATE:   cfg_r.step_rate       <= cfg_wdata[13:0];
        REG_INTEG_THR:   cfg_r.integ_threshold <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: the control word of the current step decides the exit condition.
  assign uw        = ucode_rom(step_r);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_IN:     cond_ok = in_valid;
      C_OUT:    cond_ok = slot_free;
      default:  cond_ok = 1'b1;
    endcase
  end

  assign step_nxt = cond_ok ? uw.next : step_r;
  assign in_stall = (uw.cond != C_IN);
  assign emit     = (uw.cond == C_OUT) && slot_free;

  assign ctl.mul = uw.mul;
  assign ctl.op  = uw.op;
  assign ctl.go  = cond_ok;

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_drive_r     <= dp_drive;
      out_error_now_r <= dp_error_now;
    end
  end

  rpid_dpath #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .ctl         (ctl),
    .rate_sample (in_rate_sample),
    .drive       (dp_drive),
    .error_now   (dp_error_now)
  );

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_error_now = out_error_now_r;

endmodule

// File: hw/rtl/rpid_dpath.sv
// Datapath of the rate PID: error, saturating integral, shared multiplier and drive sum.
// Driven step by step by the sequencer in the top level; depends on rpid_pkg.
module rpid_dpath import rpid_pkg::*; #(
  parameter int ACC_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  dp_ctl_t            ctl,
  input  logic signed [15:0] rate_sample,
  output logic signed [15:0] drive,
  output logic signed [16:0] error_now
);

  // Wide enough for the integral plus one increment without overflow.
  localparam int SW = ACC_WIDTH + 2;
  localparam logic signed [SW-1:0] ACC_HI = (SW'(1) << (ACC_WIDTH - 1)) - SW'(1);
  localparam logic signed [SW-1:0] ACC_LO = -(SW'(1) << (ACC_WIDTH - 1));
  localparam logic [63:0] ITERM_CLAMP = 64'd1 << 60;

  logic signed [16:0]          e_r;
  logic signed [16:0]          last_err_r;
  logic                        integ_en_r;
  logic signed [17:0]          diff_r;
  logic signed [ACC_WIDTH-1:0] integ_acc_r;
  logic signed [63:0]          prod_r;
  logic [63:0]                 ph_r;
  logic [63:0]                 amag_r;
  logic [23:0]                 gmag_r;
  logic                        ineg_r;
  logic [60:0]                 iterm_r;
  logic signed [63:0]          sum_r;
  logic                        sneg_r;
  logic [47:0]                 mag_r;

  logic signed [16:0]   e_new;
  logic [16:0]          emag_new;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [65:0]   product;
  logic signed [SW-1:0] acc_sum;
  logic signed [63:0]   acc_ext;
  logic [63:0]          iterm_raw;
  logic signed [63:0]   sum_abs;

  assign e_new    = 17'(rate_sample) - 17'($signed(cfg.setpoint));
  assign emag_new = e_new[16] ? 17'(-e_new) : 17'(e_new);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul)
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      MUL_E_PER: begin
        mul_a = 33'(e_r);
        mul_b = $signed({17'd0, cfg.step_period});
      end
      MUL_DIFF_RATE: begin
        mul_a = 33'(diff_r);
        mul_b = $signed({19'd0, cfg.step_rate});
      end
      MUL_GD_DERIV: begin
        mul_a = 33'($signed(cfg.gain_deriv));
        mul_b = 33'($signed(prod_r[31:0]));
      end
      MUL_GP_E: begin
        mul_a = 33'($signed(cfg.gain_prop));
        mul_b = 33'(e_r);
      end
      MUL_G_AH: begin
        mul_a = $signed({9'd0, gmag_r});
        mul_b = $signed({1'b0, amag_r[63:32]});
      end
      MUL_G_AL: begin
        mul_a = $signed({9'd0, gmag_r});
        mul_b = $signed({1'b0, amag_r[31:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign acc_sum = SW'(integ_acc_r) + SW'($signed(prod_r[32:0]));
  assign acc_ext = 64'(integ_acc_r);

  // High partial product at prod_r's previous step, low partial product now in prod_r.
  assign iterm_raw = {4'd0, ph_r[43:0], 16'd0} + {16'd0, prod_r[63:16]};
  assign sum_abs   = sum_r[63] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_acc_r <= '0;
      last_err_r  <= '0;
    end else if (ctl.go) begin
      if (ctl.op == OP_ACC_UPD && integ_en_r) begin
        if (acc_sum > ACC_HI) begin
          integ_acc_r <= ACC_HI[ACC_WIDTH-1:0];
        end else if (acc_sum < ACC_LO) begin
          integ_acc_r <= ACC_LO[ACC_WIDTH-1:0];
        end else begin
          integ_acc_r <= acc_sum[ACC_WIDTH-1:0];
        end
      end
      if (ctl.op == OP_EMIT) begin
        last_err_r <= e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      if (ctl.mul != MUL_NONE) begin
        prod_r <= product[63:0];
      end
      unique case (ctl.op)
        OP_LOAD: begin
          e_r        <= e_new;
          integ_en_r <= emag_new > {1'b0, cfg.integ_threshold};
        end
        OP_DIFF: begin
          diff_r <= 18'(e_r) - 18'(last_err_r);
        end
        OP_TAKE_MAG: begin
          amag_r <= acc_ext[63] ? 64'(-acc_ext) : 64'(acc_ext);
          gmag_r <= cfg.gain_integ[23] ? 24'(-$signed(cfg.gain_integ)) : cfg.gain_integ;
          ineg_r <= cfg.gain_integ[23] != integ_acc_r[ACC_WIDTH-1];
        end
        OP_SUM_LOAD: begin
          sum_r <= prod_r;
        end
        OP_SUM_ADD: begin
          sum_r <= sum_r + prod_r;
        end
        OP_PH_SAVE: begin
          ph_r <= prod_r;
        end
        OP_ITERM: begin
          // The term saturates at 2^60 once the high partial product reaches 2^44 or the sum passes 2^60.
          if (|ph_r[63:44] || iterm_raw > ITERM_CLAMP) begin
            iterm_r <= ITERM_CLAMP[60:0];
          end else begin
            iterm_r <= iterm_raw[60:0];
          end
        end
        OP_SUM_ITERM: begin
          sum_r <= ineg_r ? sum_r - $signed({3'd0, iterm_r}) : sum_r + $signed({3'd0, iterm_r});
        end
        OP_MAG: begin
          sneg_r <= sum_r[63];
          mag_r  <= sum_abs[63:16];
        end
        OP_NOP, OP_ACC_UPD, OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Truncation toward zero happened in the magnitude; saturate, then restore the sign.
  always_comb begin
    if (sneg_r) begin
      drive = (mag_r > 48'd32768) ? -16'sd32768 : $signed(16'(-mag_r[15:0]));
    end else begin
      drive = (mag_r > 48'd32767) ? 16'sd32767 : $signed(mag_r[15:0]);
    end
  end

  assign error_now = e_r;

endmodule

// File: dv/rate_pid_with_integral_threshold_test.sv
// Self-checking testbench for rate_pid_with_integral_threshold: drives gyro samples and
// register writes, predicts drive and error per transaction, and checks every result.
// Depends on rpid_pkg and the rate_pid_with_integral_threshold top level only.
module rate_pid_with_integral_threshold_test;
  import rpid_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int ACC_BITS = 48;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD_AT = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_CHUNKS = 6;
  localparam int CHUNK_ITEMS = 100;
  localparam int SOAK_ITEMS = 24;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam longint ACC_TOP = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_BOTTOM = -ACC_TOP - 1;
  localparam longint ITERM_LIMIT = longint'(1) <<< 60;

  typedef struct packed {
    logic signed [15:0] drive;
    logic signed [16:0] err;
  } loop_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_rate_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    out_drive;
  logic signed [16:0]    out_error_now;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the control registers and the loop state.
  logic signed [7:0]  m_setpoint = RST_SETPOINT;
  logic signed [23:0] m_gain_p = RST_GAIN_PROP;
  logic signed [23:0] m_gain_i = RST_GAIN_INTEG;
  logic signed [23:0] m_gain_d = RST_GAIN_DERIV;
  logic [15:0]        m_period = RST_STEP_PERIOD;
  logic [13:0]        m_rate = RST_STEP_RATE;
  logic [15:0]        m_thresh = RST_INTEG_THR;
  longint             integ_sum = 0;
  longint             prev_err = 0;

  loop_result_t       pending_results[$];
  loop_result_t       want_result;
  logic [15:0]        sample_queue[$];
  int                 pushed_count = 0;
  int                 samples_taken = 0;
  int                 results_seen = 0;
  int                 err_count = 0;
  logic               in_fire_seen = 1'b0;
  bit                 idle_enable = 1'b1;
  bit                 send_quiet = 1'b0;
  bit                 recv_quiet = 1'b0;
  bit                 long_hold_done = 1'b0;
  int                 send_gap = 0;
  int                 stall_left = 0;

  rate_pid_with_integral_threshold #(.ACC_WIDTH(ACC_BITS)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rate_sample(in_rate_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive     (out_drive),
    .out_error_now (out_error_now),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Integral gain times accumulator, back to Q.16 truncated toward zero, magnitude capped.
  function automatic longint integ_product(input logic signed [23:0] gain, input longint acc);
    longint       gl;
    logic [127:0] gm;
    logic [127:0] am;
    logic [127:0] prod;
    longint       r;
    gl = gain;
    gm = (gl < 0) ? -gl : gl;
    am = (acc < 0) ? -acc : acc;
    prod = (gm * am) >> 16;
    if (prod > 128'(ITERM_LIMIT)) prod = 128'(ITERM_LIMIT);
    r = longint'(prod[63:0]);
    return ((gl < 0) != (acc < 0)) ? -r : r;
  endfunction

  task automatic advance_loop(input logic signed [15:0] sample);
    longint       e;
    longint       emag;
    longint       next_sum;
    longint       deriv;
    longint       total;
    longint       whole;
    loop_result_t res;
    e = longint'(sample) - longint'(m_setpoint);
    emag = (e < 0) ? -e : e;
    if (emag > longint'(m_thresh)) begin
      next_sum = integ_sum + e * longint'(m_period);
      if (next_sum > ACC_TOP) integ_sum = ACC_TOP;
      else if (next_sum < ACC_BOTTOM) integ_sum = ACC_BOTTOM;
      else integ_sum = next_sum;
    end
    deriv = (e - prev_err) * longint'(m_rate);
    total = longint'(m_gain_p) * e + integ_product(m_gain_i, integ_sum)
          + longint'(m_gain_d) * deriv;
    whole = ((total < 0) ? -total : total) >> 16;
    if (total < 0) whole = -whole;
    if (whole > 32767) whole = 32767;
    if (whole < -32768) whole = -32768;
    prev_err = e;
    res.drive = whole[15:0];
    res.err = e[16:0];
    pending_results.push_back(res);
  endtask

  // Mostly back-to-back, often a short pause, now and then a long pause.
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Acceptance, prediction and result checking, all sampled at the rising edge.
  always @(posedge clk) begin
    in_fire_seen <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      advance_loop(in_rate_sample);
      samples_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("result %0d arrived with nothing pending: drive %0d error %0d",
                   results_seen, out_drive, out_error_now);
      end else begin
        want_result = pending_results.pop_front();
        if (out_drive !== want_result.drive || out_error_now !== want_result.err) begin
          err_count++;
          if (err_count <= 10)
            $display("result %0d mismatch: drive exp %0d got %0d, error exp %0d got %0d",
                     results_seen, want_result.drive, out_drive, want_result.err,
                     out_error_now);
        end
      end
    end
  end

  // Sample driver: offers the next queued sample once the current transaction is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire_seen)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_rate_sample <= sample_queue.pop_front();
        send_gap = (idle_enable && !send_quiet) ? pick_pause() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if ($urandom_range(0, 299) == 0) send_quiet = !send_quiet;
  end

  // Result receiver stalls; one long hold-off lets the block back up into its input.
  always @(negedge clk) begin
    if (!long_hold_done && samples_taken >= LONG_HOLD_AT) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_enable && !recv_quiet && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = pick_pause();
    end else begin
      out_stall <= 1'b0;
    end
    if ($urandom_range(0, 299) == 0) recv_quiet = !recv_quiet;
  end

  task automatic push_sample(input logic [15:0] value);
    sample_queue.push_back(value);
    pushed_count++;
  endtask

  // Wait until every sample is taken and every result checked, then let the pipe empty.
  task automatic settle();
    while (samples_taken != pushed_count || pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SETPOINT:    m_setpoint = value[7:0];
      REG_GAIN_PROP:   m_gain_p = value;
      REG_GAIN_INTEG:  m_gain_i = value;
      REG_GAIN_DERIV:  m_gain_d = value;
      REG_STEP_PERIOD: m_period = value[15:0];
      REG_STEP_RATE:   m_rate = value[13:0];
      REG_INTEG_THR:   m_thresh = value[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [23:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 24'($urandom());
    if (r < 80) return 24'($urandom_range(0, 1 << 18) - (1 << 17));
    if (r < 90) return 24'h7FFFFF;
    if (r < 95) return 24'h800000;
    return 24'h000000;
  endfunction

  task automatic shuffle_setup();
    int r;
    write_reg(REG_SETPOINT, 24'($urandom_range(0, 255)));
    write_reg(REG_GAIN_PROP, pick_gain());
    write_reg(REG_GAIN_INTEG, pick_gain());
    write_reg(REG_GAIN_DERIV, pick_gain());
    r = $urandom_range(0, 9);
    write_reg(REG_STEP_PERIOD, (r == 0) ? 24'd0 : (r == 1) ? 24'd1 : (r == 2) ? 24'd65535 :
                               24'($urandom_range(1, 65535)));
    r = $urandom_range(0, 9);
    write_reg(REG_STEP_RATE, (r == 0) ? 24'd0 : (r == 1) ? 24'd1 : (r == 2) ? 24'd16383 :
                             24'($urandom_range(1, 10000)));
    r = $urandom_range(0, 9);
    write_reg(REG_INTEG_THR, (r < 2) ? 24'd0 : (r == 2) ? 24'd65535 :
                             (r == 3) ? 24'($urandom_range(0, 65535)) :
                             24'($urandom_range(0, 400)));
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 24'($urandom()));
  endtask

  function automatic logic [15:0] pick_sample();
    int     r;
    longint target;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom_range(0, 600) - 300);
    if (r < 65) return 16'($urandom());
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    // Land right on or just beside the integration threshold, on either side.
    target = longint'(m_thresh) + $urandom_range(0, 1);
    if ($urandom_range(0, 1) == 1) target = -target;
    target = target + longint'(m_setpoint);
    return target[15:0];
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes and alternating bit patterns of the sample.
    push_sample(16'h0000);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0001);
    push_sample(16'hFFFF);
    push_sample(16'h5555);
    push_sample(16'hAAAA);
    push_sample(16'd100);
    settle();

    // Largest gains, period and rate; threshold so high that nothing integrates.
    write_reg(REG_SETPOINT, 24'd127);
    write_reg(REG_GAIN_PROP, 24'h7FFFFF);
    write_reg(REG_GAIN_INTEG, 24'h800000);
    write_reg(REG_GAIN_DERIV, 24'h7FFFFF);
    write_reg(REG_STEP_PERIOD, 24'd65535);
    write_reg(REG_STEP_RATE, 24'd16383);
    write_reg(REG_INTEG_THR, 24'd65535);
    write_reg(REG_SPARE, 24'hFFFFFF);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h8000);
    push_sample(16'h0000);
    settle();

    // Errors exactly at and one past the threshold, both signs.
    write_reg(REG_SETPOINT, 24'hFFFF80);
    write_reg(REG_GAIN_PROP, 24'h800000);
    write_reg(REG_GAIN_INTEG, 24'h010000);
    write_reg(REG_GAIN_DERIV, 24'h800000);
    write_reg(REG_INTEG_THR, 24'd100);
    push_sample(-16'sd28);
    push_sample(-16'sd27);
    push_sample(-16'sd228);
    push_sample(-16'sd229);
    settle();

    // A zero period stops integration; a zero rate kills the derivative.
    write_reg(REG_STEP_PERIOD, 24'd0);
    push_sample(16'd500);
    push_sample(-16'sd500);
    settle();
    write_reg(REG_STEP_PERIOD, 24'd1311);
    write_reg(REG_STEP_RATE, 24'd0);
    push_sample(16'd700);
    push_sample(-16'sd700);
    settle();

    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      shuffle_setup();
      for (int i = 0; i < CHUNK_ITEMS; i++) push_sample(pick_sample());
      settle();
    end

    // Push the integral up hard with the largest step, no idling.
    idle_enable = 1'b0;
    write_reg(REG_SETPOINT, 24'hFFFF80);
    write_reg(REG_GAIN_PROP, 24'h000100);
    write_reg(REG_GAIN_INTEG, 24'h000001);
    write_reg(REG_GAIN_DERIV, 24'h000100);
    write_reg(REG_STEP_PERIOD, 24'd65535);
    write_reg(REG_STEP_RATE, 24'd50);
    write_reg(REG_INTEG_THR, 24'd0);
    for (int i = 0; i < SOAK_ITEMS; i++) push_sample(16'h7FFF);
    settle();

    // Back off with mixed signs.
    idle_enable = 1'b1;
    write_reg(REG_SETPOINT, 24'd0);
    for (int i = 0; i < 20; i++) push_sample(pick_sample());
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    settle();

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 4_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
